// ===== design/aes256_pkg.sv =====
// Shared types, constants and byte functions for the AES-256 encryption block.
package aes256_pkg;

    typedef logic [127:0] state_t;
    typedef logic [31:0]  word_t;
    typedef logic [7:0]   byte_t;

    localparam int    Rounds     = 14;
    localparam int    KeyWords   = 8;
    localparam int    SchedWords = 4 * (Rounds + 1);
    localparam byte_t GfReduce   = 8'h1b;

    // Configuration register indexes.
    localparam logic [7:0] REG_KEY0 = 8'd0;
    localparam logic [7:0] REG_KEY1 = 8'd1;
    localparam logic [7:0] REG_KEY2 = 8'd2;
    localparam logic [7:0] REG_KEY3 = 8'd3;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiplication by two in the AES field.
    function automatic byte_t gf_double(input byte_t x);
        gf_double = {x[6:0], 1'b0} ^ (x[7] ? GfReduce : 8'h00);
    endfunction

    // S-box applied to each byte of a word.
    function automatic word_t sub_word(input word_t w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// ===== design/aes256_col_lane.sv =====
// One column lane: SubBytes, optional MixColumns and AddRoundKey on a 32-bit column.
module aes256_col_lane (
    input  aes256_pkg::word_t col_in,
    input  aes256_pkg::word_t key_word,
    input  logic              mix_en,
    output aes256_pkg::word_t col_out
);

    aes256_pkg::word_t sub;
    aes256_pkg::byte_t a0, a1, a2, a3, all_x;
    aes256_pkg::word_t mixed;

    // Substitute the four bytes of the column.
    assign sub = aes256_pkg::sub_word(col_in);

    // Mix the column with the usual doubling form.
    always_comb begin
        a0    = sub[31:24];
        a1    = sub[23:16];
        a2    = sub[15:8];
        a3    = sub[7:0];
        all_x = a0 ^ a1 ^ a2 ^ a3;
        mixed = {a0 ^ all_x ^ aes256_pkg::gf_double(a0 ^ a1),
                 a1 ^ all_x ^ aes256_pkg::gf_double(a1 ^ a2),
                 a2 ^ all_x ^ aes256_pkg::gf_double(a2 ^ a3),
                 a3 ^ all_x ^ aes256_pkg::gf_double(a3 ^ a0)};
    end

    // Add the round key word.
    assign col_out = (mix_en ? mixed : sub) ^ key_word;

endmodule

// ===== design/aes256_round.sv =====
// One AES round: ShiftRows routing into four column lanes and merging of their outputs.
module aes256_round (
    input  aes256_pkg::state_t st_in,
    input  aes256_pkg::state_t round_key,
    input  logic               mix_en,
    output aes256_pkg::state_t st_out
);

    aes256_pkg::state_t shifted;

    // ShiftRows: byte r of column c comes from column (c + r) mod 4.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[127 - 32 * c - 8 * r -: 8] = st_in[127 - 32 * ((c + r) % 4) - 8 * r -: 8];
            end
        end
    end

    // Four lanes side by side; their columns merge back into one state.
    for (genvar c = 0; c < 4; c++) begin : g_lane
        aes256_col_lane u_lane (
            .col_in   (shifted[127 - 32 * c -: 32]),
            .key_word (round_key[127 - 32 * c -: 32]),
            .mix_en   (mix_en),
            .col_out  (st_out[127 - 32 * c -: 32])
        );
    end

endmodule

// ===== design/aes256_block_encrypt.sv =====
// Top level: key schedule sequencer and fifteen-stage AES-256 round pipeline.
// Each input transaction passes one stage per round plus the key add before its result is valid.
// Throughput: one block per cycle while m_ready is high and not busy; all stages stall on a held result.
// A key register write rebuilds the schedule, one word per cycle, all 60 words; s_ready is low then.
// Reset clears the key registers and pipeline valid bits; the schedule is undefined until a key write.
module aes256_block_encrypt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_plain_high,
    input  logic [63:0] s_plain_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_cipher_high,
    output logic [63:0] m_cipher_low
);

    localparam int NRounds = aes256_pkg::Rounds;
    localparam int NWords  = aes256_pkg::SchedWords;

    logic [63:0]       key_reg [4];
    aes256_pkg::word_t sched_reg [NWords];
    aes256_pkg::word_t sched_next;
    logic              busy_reg, busy_next;
    logic [5:0]        cnt_reg, cnt_next;
    aes256_pkg::byte_t rc_reg, rc_next;
    logic              key_wr;
    logic [1:0]        key_sel;

    aes256_pkg::state_t st_reg [NRounds + 1];
    aes256_pkg::state_t rnd_out [NRounds + 1];
    logic [NRounds:0]   valid_reg;
    logic               advance;

    assign cfg_ready = 1'b1;

    // Register index decode.
    always_comb begin
        key_wr  = 1'b0;
        key_sel = 2'd0;
        unique case (cfg_index)
            aes256_pkg::REG_KEY0: begin key_wr = 1'b1; key_sel = 2'd0; end
            aes256_pkg::REG_KEY1: begin key_wr = 1'b1; key_sel = 2'd1; end
            aes256_pkg::REG_KEY2: begin key_wr = 1'b1; key_sel = 2'd2; end
            aes256_pkg::REG_KEY3: begin key_wr = 1'b1; key_sel = 2'd3; end
            default: ;
        endcase
    end

    // Key registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end else if (cfg_valid && key_wr) begin
            key_reg[key_sel] <= cfg_data;
        end
    end

    // Next schedule word: key words first, then the expansion recurrence.
    always_comb begin
        aes256_pkg::word_t t;
        t       = sched_reg[NWords - 1];
        rc_next = rc_reg;
        if (cnt_reg < 6'(aes256_pkg::KeyWords)) begin
            sched_next = cnt_reg[0] ? key_reg[cnt_reg[2:1]][31:0]
                                    : key_reg[cnt_reg[2:1]][63:32];
        end else begin
            if (cnt_reg[2:0] == 3'd0) begin
                t       = aes256_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_reg, 24'h0};
                rc_next = aes256_pkg::gf_double(rc_reg);
            end else if (cnt_reg[2:0] == 3'd4) begin
                t = aes256_pkg::sub_word(t);
            end
            sched_next = sched_reg[NWords - aes256_pkg::KeyWords] ^ t;
        end
    end

    // Sequencer control.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (cfg_valid && key_wr) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NWords - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rc_reg   <= 8'h01;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (cfg_valid && key_wr) rc_reg <= 8'h01;
            else if (busy_reg)       rc_reg <= rc_next;
        end
    end

    // Schedule shift line: new words enter at the top, word k ends at entry k.
    always_ff @(posedge aclk) begin
        if (busy_reg && !(cfg_valid && key_wr)) begin
            for (int k = 0; k < NWords - 1; k++) sched_reg[k] <= sched_reg[k + 1];
            sched_reg[NWords - 1] <= sched_next;
        end
    end

    // Pipeline flow control: the whole line moves unless the result is held.
    assign advance = !valid_reg[NRounds] || m_ready;
    assign s_ready = advance && !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[NRounds - 1:0], s_valid && !busy_reg};
        end
    end

    // Round stages.
    assign rnd_out[0] = {s_plain_high, s_plain_low}
                      ^ {sched_reg[0], sched_reg[1], sched_reg[2], sched_reg[3]};

    for (genvar r = 1; r <= NRounds; r++) begin : g_round
        aes256_round u_round (
            .st_in     (st_reg[r - 1]),
            .round_key ({sched_reg[4 * r], sched_reg[4 * r + 1],
                         sched_reg[4 * r + 2], sched_reg[4 * r + 3]}),
            .mix_en    (r != NRounds),
            .st_out    (rnd_out[r])
        );
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int r = 0; r <= NRounds; r++) st_reg[r] <= rnd_out[r];
        end
    end

    assign m_valid       = valid_reg[NRounds];
    assign m_cipher_high = st_reg[NRounds][127:64];
    assign m_cipher_low  = st_reg[NRounds][63:0];

endmodule
